// File: rtl/core/sacn_dfr_pkg.sv
// Package for the sACN DMX packet deframer.
// Holds datagram offsets, the packet identifier table and the word types.
// No dependencies.
`default_nettype none

package sacn_dfr_pkg;

  localparam int unsigned MAX_SLOTS_DEF    = 512;
  localparam int unsigned MAX_DATAGRAM_DEF = 1024;

  localparam int unsigned ID_START       = 4;
  localparam int unsigned ID_LEN         = 12;
  localparam int unsigned POS_UNI_HI     = 113;
  localparam int unsigned POS_UNI_LO     = 114;
  localparam int unsigned POS_CNT_HI     = 123;
  localparam int unsigned POS_CNT_LO     = 124;
  localparam int unsigned POS_START_CODE = 125;
  localparam int unsigned POS_FIRST_SLOT = 126;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] universe_id;
    logic [8:0]  slot_index;
    logic [7:0]  slot_value;
    logic        packet_done;
    logic        packet_accepted;
    logic [31:0] accepted_count;
  } res_word_t;

  // Expected identifier "ASC-E1.17" followed by three zero bytes.
  function automatic logic [7:0] ident_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h41;
      4'd1:    val = 8'h53;
      4'd2:    val = 8'h43;
      4'd3:    val = 8'h2D;
      4'd4:    val = 8'h45;
      4'd5:    val = 8'h31;
      4'd6:    val = 8'h2E;
      4'd7:    val = 8'h31;
      4'd8:    val = 8'h37;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sacn_dfr_in_if.sv
// Input channel of the sACN DMX packet deframer: one datagram byte per word.
// Handshake is valid/ready; no dependencies.
`default_nettype none

interface sacn_dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sacn_dfr_out_if.sv
// Result channel of the sACN DMX packet deframer: slot writes and packet status.
// Handshake is valid/ready; no dependencies.
`default_nettype none

interface sacn_dfr_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [15:0] universe_id;
  logic [8:0]  slot_index;
  logic [7:0]  slot_value;
  logic        packet_done;
  logic        packet_accepted;
  logic [31:0] accepted_count;

  modport source (output valid, output write_valid, output universe_id, output slot_index,
                  output slot_value, output packet_done, output packet_accepted,
                  output accepted_count, input ready);
  modport sink   (input valid, input write_valid, input universe_id, input slot_index,
                  input slot_value, input packet_done, input packet_accepted,
                  input accepted_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sacn_dfr_parse.sv
// Datagram parser: byte position tracking, header checks, latches and slot writes.
// Depends on sacn_dfr_pkg.
`default_nettype none

module sacn_dfr_parse #(
  parameter int unsigned MAX_SLOTS    = sacn_dfr_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAX_DATAGRAM = sacn_dfr_pkg::MAX_DATAGRAM_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire sacn_dfr_pkg::in_word_t word,
  output sacn_dfr_pkg::res_word_t     res,
  output logic                        res_hit
);
  import sacn_dfr_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1);
  localparam int unsigned LIM_W = $clog2(MAX_SLOTS + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hg_r, hg_nxt;
  logic [15:0]      uni_r, uni_nxt;
  logic [7:0]       cnt_hi_r, cnt_hi_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [31:0]      pkt_r, pkt_nxt;

  logic             in_window;
  logic [POS_W-1:0] sidx;
  logic [15:0]      cnt;
  logic [15:0]      cnt_m1;
  logic             wr;
  logic             accepted;
  logic [7:0]       b;

  always_comb begin
    b          = word.data_byte;
    pos_nxt    = pos_r;
    hg_nxt     = hg_r;
    uni_nxt    = uni_r;
    cnt_hi_nxt = cnt_hi_r;
    lim_nxt    = lim_r;
    pkt_nxt    = pkt_r;
    wr         = 1'b0;
    accepted   = 1'b0;
    in_window  = pos_r < POS_W'(MAX_DATAGRAM);
    sidx       = pos_r - POS_W'(POS_FIRST_SLOT);
    cnt        = {cnt_hi_r, b};
    cnt_m1     = cnt - 16'd1;

    if (in_window) begin
      if (pos_r >= POS_W'(ID_START) && pos_r < POS_W'(ID_START + ID_LEN)) begin
        if (b != ident_byte(pos_r[3:0] - 4'(ID_START))) begin
          hg_nxt = 1'b0;
        end
      end else if (pos_r == POS_W'(POS_UNI_HI)) begin
        uni_nxt = {b, uni_r[7:0]};
      end else if (pos_r == POS_W'(POS_UNI_LO)) begin
        uni_nxt = {uni_r[15:8], b};
      end else if (pos_r == POS_W'(POS_CNT_HI)) begin
        cnt_hi_nxt = b;
      end else if (pos_r == POS_W'(POS_CNT_LO)) begin
        // property count includes the start code; clamp to the slot range
        if (cnt == 16'd0) begin
          lim_nxt = '0;
        end else if (cnt_m1 > 16'(MAX_SLOTS)) begin
          lim_nxt = LIM_W'(MAX_SLOTS);
        end else begin
          lim_nxt = cnt_m1[LIM_W-1:0];
        end
      end else if (pos_r == POS_W'(POS_START_CODE)) begin
        if (b != 8'h00) begin
          hg_nxt = 1'b0;
        end
      end else if (pos_r >= POS_W'(POS_FIRST_SLOT)) begin
        wr = hg_r && (sidx < POS_W'(lim_r));
      end
      pos_nxt = pos_r + POS_W'(1);
    end

    if (word.last_byte) begin
      // past the window the packet is surely long enough
      accepted = hg_nxt && (!in_window || pos_r >= POS_W'(POS_START_CODE));
      if (accepted) begin
        pkt_nxt = pkt_r + 32'd1;
      end
      pos_nxt = '0;
      hg_nxt  = 1'b1;
    end

    res_hit             = wr || word.last_byte;
    res.write_valid     = wr;
    res.universe_id     = uni_nxt;
    res.slot_index      = wr ? sidx[8:0] : 9'd0;
    res.slot_value      = wr ? b : 8'd0;
    res.packet_done     = word.last_byte;
    res.packet_accepted = accepted;
    res.accepted_count  = pkt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hg_r     <= 1'b1;
      uni_r    <= '0;
      cnt_hi_r <= '0;
      lim_r    <= '0;
      pkt_r    <= '0;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      hg_r     <= hg_nxt;
      uni_r    <= uni_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      lim_r    <= lim_nxt;
      pkt_r    <= pkt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sacn_dmx_packet_deframer_top.sv
// sACN DMX packet deframer: one datagram byte per word in, slot writes and status out.
// Path: each word passes the input register, then the parser into the result register.
// Throughput: one byte per cycle unless the output stalls, set by the single-pass parser.
// Bytes that cause no result are dropped in the parser stage without a bubble.
// Reset (rst_n low, synchronous) empties both stages and returns position, header flag,
// latches and the accepted-packet counter to their initial values.
`default_nettype none

module sacn_dmx_packet_deframer_top #(
  parameter int unsigned MAX_SLOTS    = sacn_dfr_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAX_DATAGRAM = sacn_dfr_pkg::MAX_DATAGRAM_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  sacn_dfr_in_if.sink    in_ch,
  sacn_dfr_out_if.source out_ch
);
  import sacn_dfr_pkg::*;

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  res_word_t out_res_r;

  logic      adv_out;
  logic      s1_fire;
  res_word_t res;
  logic      res_hit;

  assign adv_out     = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && adv_out;
  assign in_ch.ready = !s1_valid_r || adv_out;

  sacn_dfr_parse #(
    .MAX_SLOTS    (MAX_SLOTS),
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .word    (s1_word_r),
    .res     (res),
    .res_hit (res_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_fire && res_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_word_r.data_byte <= in_ch.data_byte;
      s1_word_r.last_byte <= in_ch.last_byte;
    end
    if (s1_fire && res_hit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.write_valid     = out_res_r.write_valid;
  assign out_ch.universe_id     = out_res_r.universe_id;
  assign out_ch.slot_index      = out_res_r.slot_index;
  assign out_ch.slot_value      = out_res_r.slot_value;
  assign out_ch.packet_done     = out_res_r.packet_done;
  assign out_ch.packet_accepted = out_res_r.packet_accepted;
  assign out_ch.accepted_count  = out_res_r.accepted_count;

endmodule

`default_nettype wire
